// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define FSSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Same, on the block clock and reset.
`define FSSD_ASSERT_CLK(lbl, prop) `FSSD_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// File: rtl/core/fssd_pkg.sv
package fssd_pkg;

  typedef enum logic [1:0] {
    OP_INLET  = 2'd0,
    OP_OUTLET = 2'd1,
    OP_STEP   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_FLOW   = 3'd1,
    ST_TRANS  = 3'd2,
    ST_STEADY = 3'd3,
    ST_DONE   = 3'd4
  } stage_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_GAIN       = 3'd0;
  localparam logic [2:0] CFG_RATIO      = 3'd1;
  localparam logic [2:0] CFG_INIT_WAIT  = 3'd2;
  localparam logic [2:0] CFG_TRANS_WAIT = 3'd3;
  localparam logic [2:0] CFG_STEADY_WAIT = 3'd4;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] rate_value;
    logic [31:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  current_stage;
    logic        stage_changed;
    logic [31:0] smoothed_inflow;
    logic [31:0] smoothed_outflow;
  } out_item_t;

  typedef struct packed {
    stage_e next_stage;
    logic   changed;
  } stage_upd_t;

endpackage

// File: rtl/core/fssd_stage.sv
module fssd_stage (
  input  fssd_pkg::stage_e     stage_i,
  input  logic                 first_done_i,
  input  logic [31:0]          time_now_i,
  input  logic [31:0]          entry_time_i,
  input  logic [31:0]          init_wait_i,
  input  logic [31:0]          trans_wait_i,
  input  logic [31:0]          steady_wait_i,
  input  logic                 flow_reached_i,
  output fssd_pkg::stage_upd_t upd_o
);
  import fssd_pkg::*;

  logic [31:0] entry_eff;
  logic [31:0] wait_sel;
  logic [31:0] elapsed;
  logic        waited;

  // The first step starts the init stage at its own time.
  assign entry_eff = first_done_i ? entry_time_i : time_now_i;
  assign elapsed   = time_now_i - entry_eff;
  // Time running backwards counts as no time elapsed.
  assign waited    = (time_now_i >= entry_eff) && (elapsed > wait_sel);

  always_comb begin
    case (stage_i)
      ST_INIT:   wait_sel = init_wait_i;
      ST_TRANS:  wait_sel = trans_wait_i;
      ST_STEADY: wait_sel = steady_wait_i;
      default:   wait_sel = '1;
    endcase
  end

  always_comb begin
    upd_o.next_stage = stage_i;
    case (stage_i)
      ST_INIT: begin
        if (waited) upd_o.next_stage = ST_FLOW;
      end
      ST_FLOW: begin
        if (flow_reached_i) upd_o.next_stage = ST_TRANS;
      end
      ST_TRANS: begin
        if (waited) upd_o.next_stage = ST_STEADY;
      end
      ST_STEADY: begin
        if (waited) upd_o.next_stage = ST_DONE;
      end
      default: upd_o.next_stage = stage_i;
    endcase
    upd_o.changed = (upd_o.next_stage != stage_i);
  end

endmodule

// File: rtl/core/flow_steady_state_stage_detector_core.sv
// Flow steady-state stage detector.
// Input channel (in_valid_i / in_stall_o) carries inlet rate, outlet rate
// and end-of-step transactions. Rate transactions are taken one per cycle
// while the sequencer is idle and fold into saturating sums with no result.
// A step transaction runs a sequencer over one shared multiplier: two
// multiply passes per smoothed rate and one for the outflow/inflow ratio
// compare, the multiplier used once per cycle. Its result appears on
// out_valid_o after S_IN_A, S_IN_B, S_OUT_A, S_OUT_B, S_RATIO and S_FINISH,
// and the input stays stalled until the sequencer is back in idle.
// The result sits in an output register; when the receiver stalls, the
// sequencer holds in its last state until the register frees up, and the
// input stays stalled.
// Configuration is a write-only port (cfg_we_i, cfg_index_i, cfg_data_i),
// written by the user only while the block is idle, which is not enforced;
// unknown indexes are ignored. Reset clears sums, averages and the stage
// (init), loads the default gain and ratio, and empties the output channel.
module flow_steady_state_stage_detector_core #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  fssd_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output fssd_pkg::out_item_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [fssd_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [fssd_pkg::CfgDataWidth-1:0]     cfg_data_i
);
  import fssd_pkg::*;

  localparam int unsigned GW = FRACTION_BITS + 1;
  localparam int unsigned RW = FRACTION_BITS + 2;
  localparam int unsigned PW = 32 + RW;
  localparam logic [GW-1:0] One        = GW'(1) << FRACTION_BITS;
  localparam logic [GW-1:0] GainReset  = GW'(((1 << FRACTION_BITS) + 5) / 10);
  localparam logic [RW-1:0] RatioReset = RW'(1) << FRACTION_BITS;
  localparam logic [PW-1:0] Half       = PW'(1) << (FRACTION_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IN_A,
    S_IN_B,
    S_OUT_A,
    S_OUT_B,
    S_RATIO,
    S_FINISH
  } state_e;

  state_e      state_q;
  logic [GW-1:0] gain_q;
  logic [RW-1:0] ratio_q;
  logic [31:0] init_wait_q, trans_wait_q, steady_wait_q;
  logic [31:0] sum_in_q, sum_out_q;
  logic [31:0] avg_in_q, avg_out_q;
  logic [31:0] time_q, entry_q;
  stage_e      stage_q;
  logic        first_done_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [PW-1:0] prod_q, prod_d, acc_q, acc_d;
  logic [31:0]   mul_a;
  logic [RW-1:0] mul_b;
  logic [GW-1:0] gain_eff, keep;
  logic [PW-1:0] avg_sum;
  logic [31:0]   new_avg;
  logic          flow_reached;
  logic [32:0]   rate_sum;
  logic [31:0]   rate_sat, rate_base;
  stage_upd_t    upd;

  // Gain saturates at one; the first step takes the raw sums.
  assign gain_eff = !first_done_q ? One : ((gain_q > One) ? One : gain_q);
  assign keep     = One - gain_eff;

  always_comb begin
    case (state_q)
      S_IN_A:  begin mul_a = avg_in_q;  mul_b = RW'(keep);     end
      S_IN_B:  begin mul_a = sum_in_q;  mul_b = RW'(gain_eff); end
      S_OUT_A: begin mul_a = avg_out_q; mul_b = RW'(keep);     end
      S_OUT_B: begin mul_a = sum_out_q; mul_b = RW'(gain_eff); end
      // Hold the ratio product while the result waits for the receiver.
      S_RATIO, S_FINISH: begin mul_a = avg_in_q;  mul_b = ratio_q; end
      default: begin mul_a = '0;        mul_b = '0;            end
    endcase
  end

  assign prod_d  = PW'(mul_a) * PW'(mul_b);
  assign acc_d   = ((state_q == S_IN_B) || (state_q == S_OUT_B)) ? prod_q + Half : acc_q;
  assign avg_sum = acc_q + prod_q;
  assign new_avg = avg_sum[FRACTION_BITS +: 32];

  assign flow_reached = PW'({avg_out_q, {FRACTION_BITS{1'b0}}}) >= prod_q;

  assign rate_base = (in_data_i.opcode == OP_INLET) ? sum_in_q : sum_out_q;
  assign rate_sum  = {1'b0, rate_base} + {1'b0, in_data_i.rate_value};
  assign rate_sat  = rate_sum[32] ? '1 : rate_sum[31:0];

  fssd_stage u_stage (
    .stage_i        (stage_q),
    .first_done_i   (first_done_q),
    .time_now_i     (time_q),
    .entry_time_i   (entry_q),
    .init_wait_i    (init_wait_q),
    .trans_wait_i   (trans_wait_q),
    .steady_wait_i  (steady_wait_q),
    .flow_reached_i (flow_reached),
    .upd_o          (upd)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q        <= GainReset;
      ratio_q       <= RatioReset;
      init_wait_q   <= '0;
      trans_wait_q  <= '0;
      steady_wait_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GAIN:        gain_q        <= cfg_data_i[GW-1:0];
        CFG_RATIO:       ratio_q       <= cfg_data_i[RW-1:0];
        CFG_INIT_WAIT:   init_wait_q   <= cfg_data_i[31:0];
        CFG_TRANS_WAIT:  trans_wait_q  <= cfg_data_i[31:0];
        CFG_STEADY_WAIT: steady_wait_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Set on a finished step, drop once the receiver takes the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_FINISH) && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sum_in_q     <= '0;
      sum_out_q    <= '0;
      avg_in_q     <= '0;
      avg_out_q    <= '0;
      time_q       <= '0;
      entry_q      <= '0;
      stage_q      <= ST_INIT;
      first_done_q <= 1'b0;
      out_q        <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (in_data_i.opcode)
              OP_INLET:  sum_in_q  <= rate_sat;
              OP_OUTLET: sum_out_q <= rate_sat;
              OP_STEP: begin
                time_q  <= in_data_i.time_now;
                state_q <= S_IN_A;
              end
              default: ;
            endcase
          end
        end
        S_IN_A:  state_q <= S_IN_B;
        S_IN_B:  state_q <= S_OUT_A;
        S_OUT_A: begin
          avg_in_q <= new_avg;
          state_q  <= S_OUT_B;
        end
        S_OUT_B: state_q <= S_RATIO;
        S_RATIO: begin
          avg_out_q <= new_avg;
          state_q   <= S_FINISH;
        end
        S_FINISH: begin
          // Hold until the output register is free.
          if (!out_valid_q || !out_stall_i) begin
            stage_q <= upd.next_stage;
            if (upd.changed || !first_done_q) entry_q <= time_q;
            first_done_q           <= 1'b1;
            sum_in_q               <= '0;
            sum_out_q              <= '0;
            out_q.current_stage    <= upd.next_stage;
            out_q.stage_changed    <= upd.changed;
            out_q.smoothed_inflow  <= avg_in_q;
            out_q.smoothed_outflow <= avg_out_q;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/fssd_checker.sv
`include "assert_macros.svh"

module fssd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input fssd_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fssd_pkg::out_item_t out_data_o
);
  import fssd_pkg::*;

  // A stalled result holds.
  `FSSD_ASSERT_CLK(out_hold_a, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))

  // A step transaction blocks the input while the sequencer runs.
  `FSSD_ASSERT_CLK(step_stalls_a, (in_valid_i && !in_stall_o && in_data_i.opcode == OP_STEP) |=> in_stall_o)

  // A rate transaction never produces a result.
  `FSSD_ASSERT_CLK(rate_no_result_a, (in_valid_i && !in_stall_o && in_data_i.opcode != OP_STEP && !out_valid_o) |=> !out_valid_o)

  // Init is never entered by a change.
  `FSSD_ASSERT_CLK(change_not_init_a, (out_valid_o && out_data_o.stage_changed) |-> (out_data_o.current_stage != ST_INIT))

endmodule

bind flow_steady_state_stage_detector_core fssd_checker u_fssd_checker (.*);

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fssd_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam logic [63:0] UNITY = 64'd1 << FRAC;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRESSURE_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_PRINTED = 40;

  typedef enum {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_e;
  typedef enum {TRAFFIC_INLET_HEAVY, TRAFFIC_OUTLET_HEAVY, TRAFFIC_MIXED} traffic_e;

  typedef struct {
    row_kind_e   kind;
    in_item_t    item;
    out_item_t   want;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
  } vector_row_t;

  typedef struct {
    logic [31:0] gain;
    logic [31:0] ratio;
    logic [31:0] init_w;
    logic [31:0] trans_w;
    logic [31:0] steady_w;
    traffic_e    traffic;
    int          items;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  // Typed-in expectation that travels with the transaction it belongs to
  logic tag_typed;
  out_item_t tag_want;

  // Mirror of the detector state and registers
  logic [16:0] m_gain;
  logic [17:0] m_ratio;
  logic [31:0] m_init_wait, m_trans_wait, m_steady_wait;
  logic [31:0] m_in_sum, m_out_sum, m_in_avg, m_out_avg, m_entry;
  stage_e m_stage;
  bit m_primed;

  out_item_t expected_reports[$];
  vector_row_t script[$];
  phase_t plan[6];
  int mismatch_count = 0;
  int accepted_items = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int stage_hits[5] = '{default: 0};
  bit pressure_done = 1'b0;

  flow_steady_state_stage_detector_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] avg, logic [31:0] sum, logic [63:0] g);
    logic [63:0] acc;
    acc = (UNITY - g) * {32'd0, avg} + g * {32'd0, sum} + (UNITY >> 1);
    return 32'(acc >> FRAC);
  endfunction

  // Backward time counts as no elapsed time
  function automatic bit waited_past(logic [31:0] now, logic [31:0] wait_ticks);
    logic [31:0] elapsed;
    elapsed = (now >= m_entry) ? now - m_entry : 32'd0;
    return elapsed > wait_ticks;
  endfunction

  function automatic bit fold_transaction(input in_item_t t, output out_item_t res);
    logic [63:0] g;
    stage_e nxt;
    res = '0;
    case (t.opcode)
      OP_INLET: begin
        m_in_sum = sat_sum(m_in_sum, t.rate_value);
        return 1'b0;
      end
      OP_OUTLET: begin
        m_out_sum = sat_sum(m_out_sum, t.rate_value);
        return 1'b0;
      end
      OP_STEP: ;
      default: return 1'b0;
    endcase
    g = (64'(m_gain) > UNITY) ? UNITY : 64'(m_gain);
    if (!m_primed) begin
      m_in_avg = m_in_sum;
      m_out_avg = m_out_sum;
      m_entry = t.time_now;
    end else begin
      m_in_avg = blend(m_in_avg, m_in_sum, g);
      m_out_avg = blend(m_out_avg, m_out_sum, g);
    end
    nxt = m_stage;
    case (m_stage)
      ST_INIT: if (waited_past(t.time_now, m_init_wait)) nxt = ST_FLOW;
      ST_FLOW: begin
        if (({32'd0, m_out_avg} << FRAC) >= 64'(m_in_avg) * 64'(m_ratio)) nxt = ST_TRANS;
      end
      ST_TRANS: if (waited_past(t.time_now, m_trans_wait)) nxt = ST_STEADY;
      ST_STEADY: if (waited_past(t.time_now, m_steady_wait)) nxt = ST_DONE;
      default: ;
    endcase
    res.stage_changed = (nxt != m_stage);
    if (nxt != m_stage) begin
      m_stage = nxt;
      m_entry = t.time_now;
    end
    m_primed = 1'b1;
    m_in_sum = '0;
    m_out_sum = '0;
    res.current_stage = m_stage;
    res.smoothed_inflow = m_in_avg;
    res.smoothed_outflow = m_out_avg;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    bit made;
    bit active;
    if (rst_n) begin
      active = cfg_we;
      if (out_valid && !out_stall) begin
        active = 1'b1;
        got = out_data;
        results_seen++;
        if (got.current_stage <= ST_DONE) stage_hits[got.current_stage]++;
        if (expected_reports.size() == 0) begin
          report_mismatch("result with nothing pending", got.smoothed_inflow, '0);
        end else begin
          want = expected_reports.pop_front();
          if (got.current_stage !== want.current_stage)
            report_mismatch("stage", 32'(got.current_stage), 32'(want.current_stage));
          if (got.stage_changed !== want.stage_changed)
            report_mismatch("changed flag", 32'(got.stage_changed), 32'(want.stage_changed));
          if (got.smoothed_inflow !== want.smoothed_inflow)
            report_mismatch("inflow", got.smoothed_inflow, want.smoothed_inflow);
          if (got.smoothed_outflow !== want.smoothed_outflow)
            report_mismatch("outflow", got.smoothed_outflow, want.smoothed_outflow);
        end
      end
      if (in_valid && !in_stall) begin
        active = 1'b1;
        accepted_items++;
        made = fold_transaction(in_data, want);
        if (made) begin
          if (tag_typed) want = tag_want;
          expected_reports.push_back(want);
        end
      end
      quiet_cycles = active ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: stretches of different stall density, one long hold-off
  initial begin : stall_pattern
    int span;
    int mode;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!pressure_done && results_seen >= 120) begin
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end
      span = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic in_item_t pack_item(logic [1:0] op, logic [31:0] rate, logic [31:0] t);
    in_item_t it;
    it.opcode = op;
    it.rate_value = rate;
    it.time_now = t;
    return it;
  endfunction

  function automatic vector_row_t item_row(logic [1:0] op, logic [31:0] rate, logic [31:0] t);
    vector_row_t row;
    row = '{kind: ROW_ITEM, item: pack_item(op, rate, t), want: '0, reg_idx: '0, reg_val: '0};
    return row;
  endfunction

  function automatic vector_row_t typed_row(logic [31:0] t, stage_e stage, logic changed,
                                            logic [31:0] inflow, logic [31:0] outflow);
    vector_row_t row;
    row = item_row(OP_STEP, $urandom, t);
    row.kind = ROW_TYPED;
    row.want.current_stage = stage;
    row.want.stage_changed = changed;
    row.want.smoothed_inflow = inflow;
    row.want.smoothed_outflow = outflow;
    return row;
  endfunction

  function automatic vector_row_t cfg_row(logic [2:0] idx, logic [31:0] val);
    vector_row_t row;
    row = '{kind: ROW_CFG, item: '0, want: '0, reg_idx: idx, reg_val: val};
    return row;
  endfunction

  function automatic logic [31:0] draw_rate(bit heavy);
    return heavy ? 32'($urandom_range(1 << 28, 1 << 29)) : 32'($urandom_range(0, 1 << 24));
  endfunction

  task automatic offer_item(in_item_t item, logic typed, out_item_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data <= item;
    tag_typed <= typed;
    tag_want <= want;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Rate transactions leave no result, so allow for work still in flight
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_GAIN: m_gain = val[16:0];
      CFG_RATIO: m_ratio = val[17:0];
      CFG_INIT_WAIT: m_init_wait = val;
      CFG_TRANS_WAIT: m_trans_wait = val;
      CFG_STEADY_WAIT: m_steady_wait = val;
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int produced;
    int n_rates;
    int r;
    bit to_inlet;
    logic [31:0] rate;
    logic [31:0] sim_ticks;
    phase_t p;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    tag_typed = 1'b0;
    tag_want = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_gain = 17'd6554;
    m_ratio = 18'd65536;
    m_init_wait = '0;
    m_trans_wait = '0;
    m_steady_wait = '0;
    m_in_sum = '0;
    m_out_sum = '0;
    m_in_avg = '0;
    m_out_avg = '0;
    m_entry = '0;
    m_stage = ST_INIT;
    m_primed = 1'b0;

    // First step takes the raw sums; the stage stays in init throughout
    script.push_back(item_row(OP_INLET, 32'h0001_0000, $urandom));
    script.push_back(item_row(OP_OUTLET, 32'h0000_8000, $urandom));
    script.push_back(typed_row(32'd100, ST_INIT, 1'b0, 32'h0001_0000, 32'h0000_8000));
    script.push_back(item_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    script.push_back(item_row(OP_STEP, $urandom, 32'd100));
    script.push_back(item_row(OP_STEP, $urandom, 32'd50));
    script.push_back(item_row(OP_INLET, 32'hFFFF_FFFF, $urandom));
    script.push_back(item_row(OP_INLET, 32'h0000_0001, $urandom));
    script.push_back(item_row(OP_OUTLET, 32'hFFFF_FFFF, $urandom));
    script.push_back(item_row(OP_STEP, $urandom, 32'd0));
    script.push_back(cfg_row(CFG_SPARE_LO, 32'hFFFF_FFFF));
    script.push_back(cfg_row(CFG_SPARE_HI, 32'hFFFF_FFFF));
    // Gain above one behaves as one: averages follow the sums exactly
    script.push_back(cfg_row(CFG_GAIN, 32'hFFFF_FFFF));
    script.push_back(cfg_row(CFG_INIT_WAIT, 32'hFFFF_FFFF));
    script.push_back(item_row(OP_INLET, 32'hFFFF_FFFF, $urandom));
    script.push_back(item_row(OP_INLET, 32'hFFFF_FFFF, $urandom));
    script.push_back(item_row(OP_OUTLET, 32'h0000_0000, $urandom));
    script.push_back(typed_row(32'hFFFF_FFFF, ST_INIT, 1'b0, 32'hFFFF_FFFF, 32'h0));
    script.push_back(typed_row(32'd100, ST_INIT, 1'b0, 32'h0, 32'h0));
    // Zero gain freezes the averages
    script.push_back(cfg_row(CFG_GAIN, 32'd0));
    script.push_back(item_row(OP_INLET, 32'h1234_5678, $urandom));
    script.push_back(item_row(OP_OUTLET, 32'h00FF_0000, $urandom));
    script.push_back(typed_row(32'd7, ST_INIT, 1'b0, 32'h0, 32'h0));

    // Walk the stage sequence once: hold flow, release it, then run out the waits
    plan[0] = '{32'($urandom_range(3000, 30000)), 32'd131072, 32'd20, 32'd40, 32'd40,
                TRAFFIC_INLET_HEAVY, 200};
    plan[1] = '{32'd65536, 32'($urandom_range(65536, 131072)), 32'd20, 32'd40, 32'd40,
                TRAFFIC_INLET_HEAVY, 200};
    plan[2] = '{32'h0001_FFFF, 32'($urandom_range(16384, 98304)), 32'd20, 32'd60,
                32'hFFFF_FFFF, TRAFFIC_OUTLET_HEAVY, 200};
    plan[3] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, TRAFFIC_MIXED, 200};
    plan[4] = '{32'($urandom_range(1, 65535)), 32'($urandom_range(0, 131072)), 32'd0, 32'd0,
                32'd80, TRAFFIC_MIXED, 200};
    plan[5] = '{32'($urandom_range(0, 32'h1_FFFF)), 32'($urandom_range(0, 131072)), 32'd0,
                32'd0, 32'd0, TRAFFIC_MIXED, 200};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG: begin
          drain_results();
          write_reg(script[i].reg_idx, script[i].reg_val);
        end
        default: offer_item(script[i].item, script[i].kind == ROW_TYPED, script[i].want);
      endcase
    end

    sim_ticks = 32'd100;
    foreach (plan[ph]) begin
      p = plan[ph];
      drain_results();
      write_reg(CFG_GAIN, p.gain);
      write_reg(CFG_RATIO, p.ratio);
      write_reg(CFG_INIT_WAIT, p.init_w);
      write_reg(CFG_TRANS_WAIT, p.trans_w);
      write_reg(CFG_STEADY_WAIT, p.steady_w);
      produced = 0;
      while (produced < p.items) begin
        n_rates = (p.traffic == TRAFFIC_MIXED) ? $urandom_range(0, 4) : $urandom_range(1, 4);
        for (int k = 0; k < n_rates; k++) begin
          // Lead with the heavy side so every step sees it
          if (k == 0 && p.traffic != TRAFFIC_MIXED)
            to_inlet = (p.traffic == TRAFFIC_INLET_HEAVY);
          else
            to_inlet = 1'($urandom_range(0, 1));
          case (p.traffic)
            TRAFFIC_INLET_HEAVY: rate = draw_rate(to_inlet);
            TRAFFIC_OUTLET_HEAVY: rate = draw_rate(!to_inlet);
            default: rate = ($urandom_range(0, 3) == 0) ? $urandom : draw_rate(1'b0);
          endcase
          offer_item(pack_item(to_inlet ? OP_INLET : OP_OUTLET, rate, $urandom), 1'b0, '0);
          produced++;
        end
        if ($urandom_range(0, 19) == 0)
          offer_item(pack_item(OP_UNUSED, $urandom, $urandom), 1'b0, '0);
        r = $urandom_range(0, 63);
        if (r == 0)
          sim_ticks += $urandom_range(1000, 1 << 20);
        else if (r < 5 && sim_ticks > 32'd32)
          sim_ticks -= $urandom_range(1, 30);
        else
          sim_ticks += $urandom_range(0, 3);
        offer_item(pack_item(OP_STEP, $urandom, sim_ticks), 1'b0, '0);
        produced++;
      end
    end

    drain_results();
    $display("Run covered %0d input transactions, %0d step results, %0d register writes",
             accepted_items, results_seen, reg_writes);
    $display("Results per stage (init flow trans steady done): %0d %0d %0d %0d %0d",
             stage_hits[0], stage_hits[1], stage_hits[2], stage_hits[3], stage_hits[4]);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
